// ----- src/skth_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register map and types for the streaming k-th smallest block.
package skth_pkg;

  localparam int DATA_W    = 32;
  localparam int RANK_W    = 7;
  localparam int ADDR_W    = 2;
  localparam int PDATA_W   = 32;
  localparam int MAX_K_DEF = 64;

  localparam logic [RANK_W-1:0] RANK_RESET  = RANK_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_RANK_K = ADDR_W'(0);

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic                     shrink;  // drop the largest entry
    logic                     grow;    // store holds fewer than k entries
    logic signed [DATA_W-1:0] v;       // incoming value
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic                     short_set;
  } result_t;

endpackage

// ----- src/skth_cell.sv -----
`timescale 1ns / 1ps
// One cell of the descending sorted chain; cell 0 holds the largest kept entry.
module skth_cell (
  input  logic                              clk,
  input  logic                              en,
  input  skth_pkg::cell_ctrl_t              ctrl,
  input  logic                              valid,
  input  logic signed [skth_pkg::DATA_W-1:0] left_value,
  input  logic                              left_gt,
  input  logic signed [skth_pkg::DATA_W-1:0] right_value,
  input  logic                              right_gt,
  output logic signed [skth_pkg::DATA_W-1:0] value,
  output logic                              gt,
  output logic signed [skth_pkg::DATA_W-1:0] value_next
);
  import skth_pkg::*;

  assign gt = valid && (value > ctrl.v);

  always_comb begin
    if (ctrl.shrink) begin
      // advance every entry one place towards the head
      value_next = right_value;
    end else if (ctrl.grow) begin
      // open a slot for v below all larger entries
      value_next = gt ? value : (left_gt ? ctrl.v : left_value);
    end else begin
      // full: larger entries move up over the dropped head, v fills the gap
      value_next = right_gt ? right_value : (gt ? ctrl.v : value);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule

// ----- src/skth_out_queue.sv -----
`timescale 1ns / 1ps
// Two-entry result queue: output register plus one skid slot.
module skth_out_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  skth_pkg::result_t                 push_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [skth_pkg::DATA_W-1:0] kth_value,
  output logic                              short_set,
  output logic                              full
);
  import skth_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    head_free;

  assign head_free = !out_valid || !out_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        kth_value <= skid.kth;
        short_set <= skid.short_set;
        skid      <= push_data;
      end else begin
        kth_value <= push_data.kth;
        short_set <= push_data.short_set;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

// ----- src/streaming_kth_smallest_top.sv -----
`timescale 1ns / 1ps
// Top level: keeps the k smallest values of each set in a chain of cells.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | value, set_end
//   out     | output    | out_valid / out_stall| kth_value, short_set
//   config  | input     | APB psel / penable   | paddr, pwdata, prdata
//
// One transaction is taken per cycle while in_stall is low; the whole chain
// updates in that cycle. After rank_k is lowered mid-set, the next offered
// transaction is stalled while the chain drops its head entry each cycle,
// until no surplus entry is left. The result of a set end sits in a two-entry
// queue; in_stall also rises when both its entries are held by out_stall.
// Reset empties the store and the queue and sets rank_k to 1.
module streaming_kth_smallest_top #(
  parameter int MAX_K = skth_pkg::MAX_K_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [skth_pkg::DATA_W-1:0]  value,
  input  logic                                set_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [skth_pkg::DATA_W-1:0]  kth_value,
  output logic                                short_set,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [skth_pkg::ADDR_W-1:0]         paddr,
  input  logic [skth_pkg::PDATA_W-1:0]        pwdata,
  output logic [skth_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import skth_pkg::*;

  localparam int CW = $clog2(MAX_K + 1);

  logic [RANK_W-1:0] rank_k;
  logic [CW-1:0]     k_eff;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_grown;
  logic              accept;
  logic              shrink;
  logic              grow;
  logic              chain_en;
  logic              q_full;
  cell_ctrl_t        ctrl;
  result_t           result;

  logic signed [DATA_W-1:0] cell_value [MAX_K];
  logic signed [DATA_W-1:0] cell_next  [MAX_K];
  logic                     cell_gt    [MAX_K];
  logic                     cell_valid [MAX_K];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RANK_K) ? PDATA_W'(rank_k) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= RANK_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_RANK_K)) begin
      rank_k <= pwdata[RANK_W-1:0];
    end
  end

  always_comb begin
    if (rank_k == '0) begin
      k_eff = CW'(1);
    end else if (int'(rank_k) > MAX_K) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(rank_k);
    end
  end

  // Chain control; drop surplus entries only once a transaction is offered
  assign shrink   = in_valid && (count > k_eff);
  assign grow     = count < k_eff;
  assign in_stall = shrink || q_full;
  assign accept   = in_valid && !in_stall;
  assign chain_en = accept || shrink;

  assign ctrl.shrink = shrink;
  assign ctrl.grow   = grow;
  assign ctrl.v      = value;

  assign count_grown = grow ? count + CW'(1) : count;

  always_comb begin
    count_next = count;
    if (shrink) begin
      count_next = count - CW'(1);
    end else if (accept) begin
      count_next = set_end ? '0 : count_grown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_value;
    logic                     right_gt;

    assign cell_valid[i] = count > CW'(i);

    if (i == 0) begin : g_head
      assign left_value = cell_value[i];
      assign left_gt    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_gt    = 1'b0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_gt    = cell_gt[i+1];
    end

    skth_cell u_cell (
      .clk         (clk),
      .en          (chain_en),
      .ctrl        (ctrl),
      .valid       (cell_valid[i]),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_gt    (right_gt),
      .value       (cell_value[i]),
      .gt          (cell_gt[i]),
      .value_next  (cell_next[i])
    );
  end

  // Head cell after the update is the largest kept entry
  assign result.kth       = cell_next[0];
  assign result.short_set = count_grown < k_eff;

  skth_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && set_end),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kth_value (kth_value),
    .short_set (short_set),
    .full      (q_full)
  );

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_K)
    else $error("kept entry count above capacity");

  a_set_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && set_end) |=> (count == '0))
    else $error("store not emptied after set end");

  a_shrink_steps: assert property (@(posedge clk) disable iff (rst)
    (shrink && !$past(rst)) |=> (count == $past(count) - CW'(1)))
    else $error("shrink did not drop exactly one entry");

  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    q_full |-> out_valid)
    else $error("skid slot held while output register empty");

endmodule
